/* rtl/core/soft_timer_bank_macros.svh */
// Assertion helpers for the timer bank, clocked on clk_i, quiet in reset
`ifndef SOFT_TIMER_BANK_MACROS_SVH
`define SOFT_TIMER_BANK_MACROS_SVH

// same-cycle implication
`define STB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/stb_pkg.sv */
package stb_pkg;

  localparam int NUM_TIMERS  = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam int CMD_W      = 2;
  localparam int SLOT_W     = 3;
  localparam int PERIOD_W   = 32;
  localparam int RUN_W      = 31;
  localparam int SLOT_CMP_W = 7;   // holds NUM_TIMERS up to 127
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam logic [RUN_W-1:0] RUN_WRAP = 31'h7FFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CHECK  = 2'd3
  } cmd_e;

  // controller -> datapath
  typedef struct packed {
    logic             load_item;
    logic             walk_step;
    logic [IDX_W-1:0] walk_idx;
    logic             walk_last;
    logic             exec_cmd;
    logic             out_load;
  } stb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_is_tick;
    logic out_free;
  } stb_sts_t;

endpackage

/* rtl/core/stb_ctrl.sv */
module stb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  stb_pkg::stb_sts_t sts_i,
  output stb_pkg::stb_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } stb_state_e;

  stb_state_e                  state_q, state_d;
  logic [stb_pkg::IDX_W-1:0]   walk_idx_q, walk_idx_d;
  logic                        walk_last;

  assign walk_last = (walk_idx_q == stb_pkg::IDX_W'(stb_pkg::NUM_TIMERS - 1));

  always_comb begin
    state_d         = state_q;
    walk_idx_d      = walk_idx_q;
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.walk_idx  = walk_idx_q;
    cmd_o.walk_last = walk_last;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          walk_idx_d      = '0;
          state_d         = sts_i.in_is_tick ? ST_WALK : ST_FIN;
        end
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (walk_last) begin
          state_d = ST_FIN;
        end else begin
          walk_idx_d = walk_idx_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.exec_cmd = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      walk_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      walk_idx_q <= walk_idx_d;
    end
  end

endmodule

/* rtl/core/stb_dp.sv */
module stb_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [stb_pkg::CMD_W-1:0]        in_cmd_i,
  input  logic [stb_pkg::SLOT_W-1:0]       in_slot_i,
  input  logic [stb_pkg::PERIOD_W-1:0]     in_period_i,
  input  logic                             in_periodic_i,
  input  stb_pkg::stb_cmd_t                cmd_i,
  output stb_pkg::stb_sts_t                sts_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             out_answer_o,
  output logic [stb_pkg::RUN_W-1:0]        out_run_time_o
);

  localparam int CW = stb_pkg::COUNT_WIDTH;
  localparam int NT = stb_pkg::NUM_TIMERS;
  localparam int IW = stb_pkg::IDX_W;

  // latched item
  stb_pkg::cmd_e                cmd_q;
  logic [stb_pkg::SLOT_W-1:0]   slot_q;
  logic [CW-1:0]                period_q;
  logic                         periodic_q;

  // per-slot state
  logic [NT-1:0]                active_q;
  logic [CW-1:0]                count_q  [NT];
  logic [CW-1:0]                reload_q [NT];
  logic [NT-1:0]                fired_q;
  logic [NT-1:0]                per_q;

  logic [stb_pkg::RUN_W-1:0]    run_q;
  logic [stb_pkg::RUN_W-1:0]    run_inc;

  logic                         out_valid_q;
  logic                         answer_q;
  logic [stb_pkg::RUN_W-1:0]    out_run_q;

  logic                         slot_ok;
  logic [IW-1:0]                slot_idx;
  logic [IW-1:0]                addr;
  logic                         rd_active, rd_fired, rd_per;
  logic [CW-1:0]                rd_count, rd_reload, dec;

  logic                         cnt_we, rld_we, fired_we, per_we, act_we;
  logic [CW-1:0]                cnt_wd;
  logic                         fired_wd, act_wd;
  logic                         answer;

  assign slot_ok  = ({{(stb_pkg::SLOT_CMP_W - stb_pkg::SLOT_W){1'b0}}, slot_q}
                     < stb_pkg::SLOT_CMP_W'(NT));
  assign slot_idx = IW'(slot_q);
  assign addr     = cmd_i.walk_step ? cmd_i.walk_idx : slot_idx;

  assign rd_active = active_q[addr];
  assign rd_fired  = fired_q[addr];
  assign rd_per    = per_q[addr];
  assign rd_count  = count_q[addr];
  assign rd_reload = reload_q[addr];
  assign dec       = rd_count - 1'b1;

  assign run_inc = run_q + 1'b1;

  always_comb begin
    cnt_we   = 1'b0;
    cnt_wd   = dec;
    rld_we   = 1'b0;
    fired_we = 1'b0;
    fired_wd = 1'b0;
    per_we   = 1'b0;
    act_we   = 1'b0;
    act_wd   = 1'b0;
    answer   = 1'b0;
    if (cmd_i.walk_step) begin
      if (rd_active && (rd_count != '0)) begin
        cnt_we = 1'b1;
        if (dec == '0) begin
          fired_we = 1'b1;
          fired_wd = 1'b1;
          cnt_wd   = rd_per ? rd_reload : '0;
        end
      end
    end else if (cmd_i.exec_cmd) begin
      unique case (cmd_q)
        stb_pkg::CMD_TICK: begin
          answer = 1'b0;
        end
        stb_pkg::CMD_CREATE: begin
          if (slot_ok) begin
            cnt_we   = 1'b1;
            cnt_wd   = period_q;
            rld_we   = 1'b1;
            fired_we = 1'b1;
            fired_wd = 1'b0;
            per_we   = 1'b1;
            act_we   = 1'b1;
            act_wd   = 1'b1;
            answer   = 1'b1;
          end
        end
        stb_pkg::CMD_REMOVE: begin
          if (slot_ok && rd_active) begin
            act_we = 1'b1;
            act_wd = 1'b0;
            answer = 1'b1;
          end
        end
        stb_pkg::CMD_CHECK: begin
          if (slot_ok && rd_active && rd_fired) begin
            fired_we = 1'b1;
            fired_wd = 1'b0;
            act_we   = !rd_per;
            act_wd   = 1'b0;
            answer   = 1'b1;
          end
        end
        default: begin
          answer = 1'b0;
        end
      endcase
    end
  end

  // item latch, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cmd_q      <= stb_pkg::cmd_e'(in_cmd_i);
      slot_q     <= in_slot_i;
      period_q   <= CW'(in_period_i);
      periodic_q <= in_periodic_i;
    end
  end

  // slot payload, undefined until created
  always_ff @(posedge clk_i) begin
    if (cnt_we)   count_q[addr]  <= cnt_wd;
    if (rld_we)   reload_q[addr] <= period_q;
    if (fired_we) fired_q[addr]  <= fired_wd;
    if (per_we)   per_q[addr]    <= periodic_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (act_we) active_q[addr] <= act_wd;
      if (cmd_i.walk_step && cmd_i.walk_last) begin
        run_q <= (run_inc == stb_pkg::RUN_WRAP) ? '0 : run_inc;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      answer_q  <= answer;
      out_run_q <= run_q;
    end
  end

  assign sts_o.in_is_tick = (in_cmd_i == stb_pkg::CMD_TICK);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_answer_o   = answer_q;
  assign out_run_time_o = out_run_q;

endmodule

/* rtl/core/soft_timer_bank.sv */
// Channel   | Dir | Signals                       | Contents
// s_axis    | in  | tvalid tready tdata tuser     | command: slot, period, periodic; tuser cmd
// m_axis    | out | tvalid tready tdata           | result: answer, run_time
//
// Sequencing: one item at a time. A tick walks the slot bank one slot per cycle and
// then loads the result register from the finish state; create, remove and check
// go straight to the finish state. The single read/write port on the slot bank sets this.
// Reset: slot_active and the run-time counter clear at once; no clearing pass.
// Stalls: a result waits in the output register; a new command is taken
// meanwhile, and its result is held back until the register frees.
`include "soft_timer_bank_macros.svh"

module soft_timer_bank (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: slot[2:0], period[34:3], periodic[35], zero pad [39:36]
  input  logic [stb_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // tuser: cmd[1:0]
  input  logic [stb_pkg::CMD_W-1:0]        s_axis_tuser_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: answer[0], run_time[31:1]
  output logic [stb_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i
);

  localparam int SLOT_LO   = 0;
  localparam int PERIOD_LO = SLOT_LO + stb_pkg::SLOT_W;
  localparam int PER_BIT   = PERIOD_LO + stb_pkg::PERIOD_W;

  stb_pkg::stb_cmd_t            cmd;
  stb_pkg::stb_sts_t            sts;
  logic                         out_answer;
  logic [stb_pkg::RUN_W-1:0]    out_run_time;

  // sequencing: idle / slot walk / finish
  stb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot bank, run-time counter, output register
  stb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_cmd_i       (s_axis_tuser_i),
    .in_slot_i      (s_axis_tdata_i[PERIOD_LO-1:SLOT_LO]),
    .in_period_i    (s_axis_tdata_i[PER_BIT-1:PERIOD_LO]),
    .in_periodic_i  (s_axis_tdata_i[PER_BIT]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_answer_o   (out_answer),
    .out_run_time_o (out_run_time)
  );

  assign m_axis_tdata_o = {out_run_time, out_answer};

  // a result is only written into a free output register
  `STB_ASSERT_NOW(a_load_free, cmd.out_load, sts.out_free, "result loaded over pending result")
  // one item in flight: after a transfer the input side closes
  `STB_ASSERT_NEXT(a_one_item, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o,
    "input taken twice in a row")
  // a taken result with no new one behind it leaves the output empty
  `STB_ASSERT_NEXT(a_out_drain, m_axis_tvalid_o && m_axis_tready_i && !cmd.out_load,
    !m_axis_tvalid_o, "result repeated")
  // slot walk never overlaps command execution or item load
  `STB_ASSERT_NOW(a_walk_excl, cmd.walk_step, !cmd.exec_cmd && !cmd.load_item,
    "walk overlaps command")

endmodule

/* sim/tb_soft_timer_bank.sv */
module tb_soft_timer_bank;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 2 * (stb_pkg::NUM_TIMERS + 2);

  typedef struct packed {
    logic                      answer;
    logic [stb_pkg::RUN_W-1:0] run_time;
  } result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic [stb_pkg::IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [stb_pkg::CMD_W-1:0]      s_axis_tuser_i = '0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [stb_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;

  soft_timer_bank dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the timer bank
  // ---------------------------------------------------------------------------
  logic                            timer_live   [stb_pkg::NUM_TIMERS];
  logic [stb_pkg::COUNT_WIDTH-1:0] timer_count  [stb_pkg::NUM_TIMERS];
  logic [stb_pkg::COUNT_WIDTH-1:0] timer_reload [stb_pkg::NUM_TIMERS];
  logic                            timer_fired  [stb_pkg::NUM_TIMERS];
  logic                            timer_repeat [stb_pkg::NUM_TIMERS];
  logic [stb_pkg::RUN_W-1:0]       ticks_run;

  result_t expected_results [$];
  int      burst_left;
  int      mismatch_cnt;
  int      result_cnt;
  int      cycle_cnt;

  initial begin
    for (int i = 0; i < stb_pkg::NUM_TIMERS; i++) begin
      timer_live[i]   = 1'b0;
      timer_count[i]  = '0;
      timer_reload[i] = '0;
      timer_fired[i]  = 1'b0;
      timer_repeat[i] = 1'b0;
    end
    ticks_run    = '0;
    burst_left   = 0;
    mismatch_cnt = 0;
    result_cnt   = 0;
  end

  // One command applied to the shadow bank; returns the result it produces.
  function automatic result_t timer_bank_step(stb_pkg::cmd_e c,
                                              logic [stb_pkg::SLOT_W-1:0] s,
                                              logic [stb_pkg::PERIOD_W-1:0] p,
                                              logic per);
    result_t                         r;
    logic                            in_range;
    int                              idx;
    logic [stb_pkg::COUNT_WIDTH-1:0] load;
    r.answer = 1'b0;
    in_range = (int'(s) < stb_pkg::NUM_TIMERS);
    idx      = in_range ? int'(s) : 0;
    load     = p[stb_pkg::COUNT_WIDTH-1:0];
    case (c)
      stb_pkg::CMD_TICK: begin
        for (int i = 0; i < stb_pkg::NUM_TIMERS; i++) begin
          if (timer_live[i] && timer_count[i] != '0) begin
            timer_count[i] = timer_count[i] - 1'b1;
            if (timer_count[i] == '0) begin
              timer_fired[i] = 1'b1;
              if (timer_repeat[i]) timer_count[i] = timer_reload[i];
            end
          end
        end
        // counter never holds the wrap constant itself
        if (ticks_run == stb_pkg::RUN_WRAP - 1'b1) ticks_run = '0;
        else ticks_run = ticks_run + 1'b1;
      end
      stb_pkg::CMD_CREATE: begin
        if (in_range) begin
          timer_count[idx]  = load;
          timer_reload[idx] = load;
          timer_fired[idx]  = 1'b0;
          timer_repeat[idx] = per;
          timer_live[idx]   = 1'b1;
          r.answer          = 1'b1;
        end
      end
      stb_pkg::CMD_REMOVE: begin
        if (in_range && timer_live[idx]) begin
          timer_live[idx] = 1'b0;
          r.answer        = 1'b1;
        end
      end
      default: begin
        if (in_range && timer_live[idx] && timer_fired[idx]) begin
          timer_fired[idx] = 1'b0;
          if (!timer_repeat[idx]) timer_live[idx] = 1'b0;
          r.answer = 1'b1;
        end
      end
    endcase
    r.run_time = ticks_run;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps in between
  // ---------------------------------------------------------------------------
  task automatic send_cmd(stb_pkg::cmd_e c, logic [stb_pkg::SLOT_W-1:0] s,
                          logic [stb_pkg::PERIOD_W-1:0] p, logic per);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // now and then a long stretch with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 10);
    end
    s_axis_tdata_i  <= {4'b0000, per, p, s};
    s_axis_tuser_i  <= c;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
    expected_results.push_back(timer_bank_step(c, s, p, per));
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic wait_all_results();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern switches among four modes, from always ready to ready on sparse cycles
  // ---------------------------------------------------------------------------
  int rx_cnt = 0;
  int rx_mode = 0;

  always @(posedge clk_i) begin
    rx_cnt = rx_cnt + 1;
    if (rx_cnt % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= 1'($urandom_range(0, 1));
      2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready_i <= (rx_cnt % 8 == 0);
    endcase
  end

  // Result checker: every transfer out is matched to the oldest prediction
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.answer   = m_axis_tdata_o[0];
      got.run_time = m_axis_tdata_o[stb_pkg::RUN_W:1];
      result_cnt++;
      if (expected_results.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("result %0d: unexpected transfer, answer %0d run_time %0d",
                   result_cnt, got.answer, got.run_time);
        mismatch_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (got.answer !== want.answer || got.run_time !== want.run_time) begin
          if (mismatch_cnt < 10)
            $display("result %0d: answer exp %0d got %0d, run_time exp %0d got %0d",
                     result_cnt, want.answer, got.answer, want.run_time, got.run_time);
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  task automatic test_free_slots();
    send_cmd(stb_pkg::CMD_CHECK, 3'd0, 32'h0000_0000, 1'b0);   // check of a free slot
    send_cmd(stb_pkg::CMD_REMOVE, 3'd7, 32'hFFFF_FFFF, 1'b1);  // remove of a free slot
    send_cmd(stb_pkg::CMD_TICK, 3'd7, 32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_one_shot();
    send_cmd(stb_pkg::CMD_CREATE, 3'd0, 32'd1, 1'b0);
    send_cmd(stb_pkg::CMD_TICK, 3'd0, 32'd0, 1'b0);
    send_cmd(stb_pkg::CMD_CHECK, 3'd0, 32'd0, 1'b0);   // fired
    send_cmd(stb_pkg::CMD_CHECK, 3'd0, 32'd0, 1'b0);   // freed by the first check
    send_cmd(stb_pkg::CMD_REMOVE, 3'd0, 32'd0, 1'b0);
  endtask

  task automatic test_periodic();
    send_cmd(stb_pkg::CMD_CREATE, 3'd7, 32'd2, 1'b1);
    repeat (2) send_cmd(stb_pkg::CMD_TICK, 3'd0, 32'd0, 1'b0);
    send_cmd(stb_pkg::CMD_CHECK, 3'd7, 32'd0, 1'b0);
    repeat (2) send_cmd(stb_pkg::CMD_TICK, 3'd0, 32'd0, 1'b0);
    send_cmd(stb_pkg::CMD_CHECK, 3'd7, 32'd0, 1'b0);   // reloaded and fired again
    send_cmd(stb_pkg::CMD_REMOVE, 3'd7, 32'd0, 1'b0);
  endtask

  task automatic test_zero_period();
    send_cmd(stb_pkg::CMD_CREATE, 3'd3, 32'd0, 1'b0);
    send_cmd(stb_pkg::CMD_TICK, 3'd0, 32'd0, 1'b0);
    send_cmd(stb_pkg::CMD_CHECK, 3'd3, 32'd0, 1'b0);   // never fires
    send_cmd(stb_pkg::CMD_REMOVE, 3'd3, 32'd0, 1'b0);  // but stays active
  endtask

  task automatic test_overwrite();
    send_cmd(stb_pkg::CMD_CREATE, 3'd5, 32'hFFFF_FFFF, 1'b1);
    send_cmd(stb_pkg::CMD_CREATE, 3'd5, 32'd1, 1'b0);  // slot in use, overwritten
    send_cmd(stb_pkg::CMD_TICK, 3'd0, 32'd0, 1'b0);
    send_cmd(stb_pkg::CMD_CHECK, 3'd5, 32'd0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly short periods so timers fire and reload often
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(int n);
    int                           pick;
    stb_pkg::cmd_e                c;
    logic [stb_pkg::PERIOD_W-1:0] p;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) c = stb_pkg::CMD_TICK;
      else if (pick < 65) c = stb_pkg::CMD_CREATE;
      else if (pick < 88) c = stb_pkg::CMD_CHECK;
      else c = stb_pkg::CMD_REMOVE;
      if (c == stb_pkg::CMD_CREATE) begin
        case ($urandom_range(0, 9))
          0: p = '0;
          1: p = $urandom;
          2: p = '1;
          default: p = $urandom_range(1, 10);
        endcase
      end else begin
        p = $urandom;   // ignored by the block, toggles the bits anyway
      end
      send_cmd(c, stb_pkg::SLOT_W'($urandom_range(0, stb_pkg::NUM_TIMERS - 1)), p,
               1'($urandom_range(0, 1)));
      if (k == n / 2) wait_all_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_free_slots();
    test_one_shot();
    wait_all_results();
    test_periodic();
    test_zero_period();
    test_overwrite();
    wait_all_results();
    test_random_traffic(900);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
